// ===== sv/ledsw_pkg.sv =====
package ledsw_pkg;

  localparam int CFG_DATA_W = 5;

  localparam logic [4:0] PHASE_IDLE = 5'd31;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_CHIP_MODE   = 1'b0,
    REG_FRAME_BYTES = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_FILL    = 2'd2,
    ACT_REFRESH = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    OP_END  = 4'd0,
    OP_STB0 = 4'd1,
    OP_STB1 = 4'd2,
    OP_CLK0 = 4'd3,
    OP_CLK1 = 4'd4,
    OP_DAT0 = 4'd5,
    OP_DAT1 = 4'd6,
    OP_BYTE = 4'd7,
    OP_BUF  = 4'd8
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } entry_t;

  // Pin levels and busy flag, as seen on the result channel.
  typedef struct packed {
    logic clk_pin;
    logic dat_pin;
    logic strobe_pin;
    logic busy;
  } pins_t;

  localparam logic [7:0] CMD_LEAD    = 8'h03;
  localparam logic [7:0] CMD_DATA    = 8'h40;
  localparam logic [7:0] CMD_ADDR    = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY = 8'h80 | 8'h0F;

  // Frame sequence of both variants; a phase past the end reads as the end mark.
  function automatic entry_t seq_entry(input logic mode, input logic [4:0] phase);
    entry_t e;
    e = '{op: OP_END, data: 8'h00};
    if (mode == 1'b0) begin
      case (phase)
        5'd0:    e.op = OP_STB0;
        5'd1:    e = '{op: OP_BYTE, data: CMD_LEAD};
        5'd2:    e.op = OP_STB1;
        5'd3:    e.op = OP_STB0;
        5'd4:    e = '{op: OP_BYTE, data: CMD_DATA};
        5'd5:    e.op = OP_STB1;
        5'd6:    e.op = OP_STB0;
        5'd7:    e = '{op: OP_BYTE, data: CMD_ADDR};
        5'd8:    e.op = OP_BUF;
        5'd9:    e.op = OP_STB1;
        5'd10:   e.op = OP_STB0;
        5'd11:   e = '{op: OP_BYTE, data: CMD_DISPLAY};
        5'd12:   e.op = OP_STB1;
        default: e.op = OP_END;
      endcase
    end else begin
      case (phase)
        5'd0:    e.op = OP_DAT1;
        5'd1:    e.op = OP_CLK1;
        5'd2:    e.op = OP_DAT0;
        5'd3:    e.op = OP_CLK0;
        5'd4:    e = '{op: OP_BYTE, data: CMD_DATA};
        5'd5:    e.op = OP_DAT0;
        5'd6:    e.op = OP_CLK1;
        5'd7:    e.op = OP_DAT1;
        5'd8:    e.op = OP_DAT0;
        5'd9:    e.op = OP_CLK0;
        5'd10:   e = '{op: OP_BYTE, data: CMD_ADDR};
        5'd11:   e.op = OP_BUF;
        5'd12:   e.op = OP_DAT0;
        5'd13:   e.op = OP_CLK1;
        5'd14:   e.op = OP_DAT1;
        5'd15:   e.op = OP_DAT0;
        5'd16:   e.op = OP_CLK0;
        5'd17:   e = '{op: OP_BYTE, data: CMD_DISPLAY};
        5'd18:   e.op = OP_DAT0;
        5'd19:   e.op = OP_CLK1;
        5'd20:   e.op = OP_DAT1;
        default: e.op = OP_END;
      endcase
    end
    return e;
  endfunction

endpackage

// ===== sv/ledsw_frame.sv =====
module ledsw_frame import ledsw_pkg::*; #(
  parameter int BUFFER_BYTES = 16,
  localparam int IdxW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1,
  localparam int CntW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  action_t         action,
  input  logic            chip_mode,
  input  logic [CntW-1:0] send_count,
  input  logic [7:0]      buf_byte,
  output logic [IdxW-1:0] buf_addr,
  output pins_t           pins_now,
  output pins_t           pins_next
);

  logic [4:0]      phase;
  logic [CntW-1:0] byte_counter;
  logic [2:0]      bit_counter;
  logic [1:0]      bit_substep;
  logic            clock_level;
  logic            data_level;
  logic            strobe_level;

  logic [4:0]      phase_next;
  logic [CntW-1:0] byte_counter_next;
  logic [2:0]      bit_counter_next;
  logic [1:0]      bit_substep_next;
  logic            clock_level_next;
  logic            data_level_next;
  logic            strobe_level_next;

  assign buf_addr = byte_counter[IdxW-1:0];

  always_comb begin
    entry_t     e0;
    entry_t     e;
    entry_t     e_after;
    logic       skip;
    logic       advance;
    logic       stop;
    logic [4:0] ph;
    logic [7:0] byte_v;

    phase_next        = phase;
    byte_counter_next = byte_counter;
    bit_counter_next  = bit_counter;
    bit_substep_next  = bit_substep;
    clock_level_next  = clock_level;
    data_level_next   = data_level;
    strobe_level_next = strobe_level;

    e0      = seq_entry(chip_mode, phase);
    skip    = (e0.op == OP_BUF) && (byte_counter >= send_count);
    ph      = skip ? phase + 5'd1 : phase;
    e       = seq_entry(chip_mode, ph);
    byte_v  = (e.op == OP_BUF) ? buf_byte : e.data;
    advance = 1'b0;
    stop    = 1'b0;
    e_after = seq_entry(chip_mode, ph + 5'd1);

    if (step && action == ACT_REFRESH && phase == PHASE_IDLE) begin
      phase_next        = 5'd0;
      byte_counter_next = '0;
      bit_counter_next  = 3'd0;
      bit_substep_next  = 2'd0;
    end else if (step && action == ACT_TICK && phase != PHASE_IDLE) begin
      if (e0.op == OP_END) begin
        phase_next = PHASE_IDLE;
      end else begin
        // A buffer section with no bytes left to send is skipped in the same tick.
        phase_next = ph;
        if (skip) begin
          byte_counter_next = '0;
          bit_counter_next  = 3'd0;
          bit_substep_next  = 2'd0;
        end
        case (e.op)
          OP_STB0: begin strobe_level_next = 1'b0; advance = 1'b1; end
          OP_STB1: begin strobe_level_next = 1'b1; advance = 1'b1; end
          OP_CLK0: begin clock_level_next = 1'b0; advance = 1'b1; end
          OP_CLK1: begin clock_level_next = 1'b1; advance = 1'b1; end
          OP_DAT0: begin data_level_next = 1'b0; advance = 1'b1; end
          OP_DAT1: begin data_level_next = 1'b1; advance = 1'b1; end
          OP_BYTE, OP_BUF: begin
            if (bit_substep_next == 2'd0) begin
              data_level_next  = byte_v[bit_counter_next];
              bit_substep_next = 2'd1;
            end else if (bit_substep_next == 2'd1) begin
              clock_level_next = 1'b1;
              bit_substep_next = 2'd2;
            end else begin
              clock_level_next = 1'b0;
              bit_substep_next = 2'd0;
              if (bit_counter_next == 3'd7) begin
                bit_counter_next = 3'd0;
                if (e.op == OP_BUF) begin
                  byte_counter_next = byte_counter_next + CntW'(1);
                end else begin
                  advance = 1'b1;
                end
              end else begin
                bit_counter_next = bit_counter_next + 3'd1;
              end
            end
          end
          default: stop = 1'b1;
        endcase
        if (advance) begin
          phase_next        = ph + 5'd1;
          byte_counter_next = '0;
          bit_counter_next  = 3'd0;
          bit_substep_next  = 2'd0;
        end
        // The frame ends on the tick that makes the last pin change.
        if (stop) begin
          phase_next = PHASE_IDLE;
        end else if (advance && e_after.op == OP_END) begin
          phase_next = PHASE_IDLE;
        end else if (!advance && e.op == OP_END) begin
          phase_next = PHASE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_IDLE;
      byte_counter <= '0;
      bit_counter  <= 3'd0;
      bit_substep  <= 2'd0;
      clock_level  <= 1'b1;
      data_level   <= 1'b1;
      strobe_level <= 1'b1;
    end else begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      bit_counter  <= bit_counter_next;
      bit_substep  <= bit_substep_next;
      clock_level  <= clock_level_next;
      data_level   <= data_level_next;
      strobe_level <= strobe_level_next;
    end
  end

  assign pins_now = '{clk_pin: clock_level, dat_pin: data_level,
                      strobe_pin: strobe_level, busy: phase != PHASE_IDLE};
  assign pins_next = '{clk_pin: clock_level_next, dat_pin: data_level_next,
                       strobe_pin: strobe_level_next, busy: phase_next != PHASE_IDLE};

endmodule

// ===== sv/led_driver_serial_frame_writer.sv =====
// Pins update in one pass; each result word is registered into the output buffer.
// Throughput: one input word per cycle unless the output buffer is full.
// A two-word output buffer lets the input side keep going while a result waits.
// Reset (rst, synchronous): display buffer zero, frame idle, all pins high,
// chip_mode 1, frame_bytes 16, output buffer empty.
module led_driver_serial_frame_writer import ledsw_pkg::*; #(
  parameter int BUFFER_BYTES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            action,
  input  logic [3:0]            index,
  input  logic [7:0]            value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  clk_pin,
  output logic                  dat_pin,
  output logic                  strobe_pin,
  output logic                  busy_res,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IdxW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int CntW = $clog2(BUFFER_BYTES + 1);

  logic            chip_mode;
  logic [4:0]      frame_bytes;
  logic [7:0]      display_buffer [BUFFER_BYTES];
  logic [CntW-1:0] send_count;
  logic [IdxW-1:0] buf_addr;
  logic            push;
  logic            pop;
  action_t         act;
  pins_t           pins_now;
  pins_t           pins_next;
  pins_t           q0;
  pins_t           q1;
  logic [1:0]      count;

  assign act      = action_t'(action);
  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_mode   <= 1'b1;
      frame_bytes <= 5'd16;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_CHIP_MODE:   chip_mode   <= cfg_data[0];
        REG_FRAME_BYTES: frame_bytes <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign send_count = (32'(frame_bytes) > BUFFER_BYTES) ? CntW'(BUFFER_BYTES)
                                                        : CntW'(frame_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        display_buffer[i] <= 8'h00;
      end
    end else if (push && act == ACT_WRITE) begin
      if (32'(index) < BUFFER_BYTES) begin
        display_buffer[IdxW'(index)] <= value;
      end
    end else if (push && act == ACT_FILL) begin
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        display_buffer[i] <= (value == 8'd1) ? 8'hFF : 8'h00;
      end
    end
  end

  ledsw_frame #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .step      (push),
    .action    (act),
    .chip_mode (chip_mode),
    .send_count(send_count),
    .buf_byte  (display_buffer[buf_addr]),
    .buf_addr  (buf_addr),
    .pins_now  (pins_now),
    .pins_next (pins_next)
  );

  // Two-word result buffer; q0 is the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) q0 <= pins_next;
        else q1 <= pins_next;
      end
      2'b01: q0 <= q1;
      2'b11: begin
        if (count == 2'd1) begin
          q0 <= pins_next;
        end else begin
          q0 <= q1;
          q1 <= pins_next;
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = (count != 2'd0);
  assign clk_pin    = q0.clk_pin;
  assign dat_pin    = q0.dat_pin;
  assign strobe_pin = q0.strobe_pin;
  assign busy_res   = q0.busy;

`ifndef SYNTH
  a_stall_means_pending: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_second_word_kept: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && pop && !push) |=> out_valid)
    else $error("buffered result lost after a pop");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (!pins_now.busy && !(push && act == ACT_REFRESH)) |=> !pins_now.busy)
    else $error("frame started without a refresh");

  a_idle_pins_hold: assert property (@(posedge clk) disable iff (rst)
    (!pins_now.busy && push) |-> (pins_next.clk_pin == pins_now.clk_pin &&
                                  pins_next.dat_pin == pins_now.dat_pin &&
                                  pins_next.strobe_pin == pins_now.strobe_pin))
    else $error("pins moved while no frame was running");
`endif

endmodule
